[design/hidp_pkg.sv]
package hidp_pkg;

  localparam int MAX_DEPTH_DEF   = 15;
  localparam int OFFSET_BITS_DEF = 16;

  localparam logic [3:0] KIND_INPUT      = 4'd0;
  localparam logic [3:0] KIND_OUTPUT     = 4'd1;
  localparam logic [3:0] KIND_COLLECTION = 4'd2;
  localparam logic [3:0] KIND_FEATURE    = 4'd3;
  localparam logic [3:0] KIND_END_COLL   = 4'd4;
  localparam logic [3:0] KIND_KNOWN      = 4'd5;
  localparam logic [3:0] KIND_RESERVED   = 4'd6;
  localparam logic [3:0] KIND_LONG       = 4'd7;
  localparam logic [3:0] KIND_NULL       = 4'd8;

  localparam logic [7:0] TAG_MASK        = 8'hfc;
  localparam logic [7:0] TAG_INPUT       = 8'h80;
  localparam logic [7:0] TAG_OUTPUT      = 8'h90;
  localparam logic [7:0] TAG_COLLECTION  = 8'ha0;
  localparam logic [7:0] TAG_FEATURE     = 8'hb0;
  localparam logic [7:0] TAG_END_COLL    = 8'hc0;
  localparam logic [7:0] LONG_PREFIX     = 8'hfe;

  localparam logic [31:0] MAX_COLL_TYPE  = 32'd6;

  typedef enum logic [3:0] {
    PH_PREFIX = 4'b0001,
    PH_SHORT  = 4'b0010,
    PH_LSIZE  = 4'b0100,
    PH_LBODY  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  prefix;
    logic [2:0]  size;
    logic [31:0] value;
    logic [15:0] offset;
    logic [3:0]  depth;
    logic        reserved;
    logic        depth_err;
    logic        done;
  } result_t;

  function automatic logic [2:0] size_of(input logic [7:0] prefix);
    logic [2:0] s;
    case (prefix[1:0])
      2'd0: s = 3'd0;
      2'd1: s = 3'd1;
      2'd2: s = 3'd2;
      default: s = 3'd4;
    endcase
    return s;
  endfunction

  function automatic logic is_known_tag(input logic [7:0] tag);
    logic k;
    case (tag)
      8'h04, 8'h08, 8'h14, 8'h18, 8'h24, 8'h28, 8'h34, 8'h38,
      8'h44, 8'h48, 8'h54, 8'h58, 8'h64, 8'h74, 8'h78, 8'h84,
      8'h88, 8'h94, 8'h98, 8'ha4, 8'ha8, 8'hb4: k = 1'b1;
      default: k = 1'b0;
    endcase
    return k;
  endfunction

endpackage

[design/hid_descriptor_item_parser_unit.sv]
// HID report descriptor item parser. One descriptor byte is taken per beat, and the
// block accepts a byte in every cycle as long as the result side keeps up; the parse
// state is updated and a completed item is decoded in a single pass between the state
// registers and the result register. The byte that completes an item loads its result
// into the output register, or into the one skid entry while out_stall holds a result
// there, so a new byte can still enter; in_stall rises only once both hold.
module hid_descriptor_item_parser_unit #(
  parameter int MAX_DEPTH   = hidp_pkg::MAX_DEPTH_DEF,
  parameter int OFFSET_BITS = hidp_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  desc_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  item_kind,
  output logic [7:0]  item_prefix,
  output logic [2:0]  data_size,
  output logic [31:0] item_value,
  output logic [15:0] item_offset,
  output logic [3:0]  nesting_depth,
  output logic        reserved_flag,
  output logic        depth_error,
  output logic        descriptor_done
);
  import hidp_pkg::*;

  localparam int DEPTH_BITS = $clog2(MAX_DEPTH + 1);
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = DEPTH_BITS'(MAX_DEPTH);

  logic                   trailing_null_ends;
  phase_t                 phase, phase_next;
  logic [7:0]             held_prefix, held_prefix_next;
  logic [8:0]             bytes_left, bytes_left_next;
  logic [1:0]             byte_slot, byte_slot_next;
  logic [31:0]            value_acc, value_acc_next;
  logic [OFFSET_BITS-1:0] position, position_next;
  logic [OFFSET_BITS-1:0] item_start, item_start_next;
  logic [DEPTH_BITS-1:0]  coll_depth, coll_depth_next;

  result_t out_reg, skid_reg, res_new;
  logic    skid_valid, produce, accept;

  logic [7:0]            sh_prefix, sh_tag;
  logic [31:0]           sh_value;
  logic [3:0]            sh_kind;
  logic                  sh_res, sh_derr;
  logic [DEPTH_BITS-1:0] sh_depth_next, sh_dout;
  logic [31:0]           start_wide, pos_wide, cd_wide, sh_dout_wide;
  logic [31:0]           acc_merged;
  logic [8:0]            bl_dec;

  assign accept   = in_valid && !in_stall;
  assign in_stall = skid_valid;

  assign acc_merged   = value_acc | (32'(desc_byte) << {byte_slot, 3'b000});
  assign bl_dec       = bytes_left - 9'd1;
  assign start_wide   = 32'(item_start);
  assign pos_wide     = 32'(position);
  assign cd_wide      = 32'(coll_depth);
  assign sh_dout_wide = 32'(sh_dout);

  // Classification of a finished short item.
  always_comb begin
    sh_prefix = (phase == PH_PREFIX) ? desc_byte : held_prefix;
    sh_value  = (phase == PH_PREFIX) ? 32'd0 : acc_merged;
    sh_tag    = sh_prefix & TAG_MASK;
    sh_kind   = KIND_RESERVED;
    sh_res    = 1'b0;
    sh_derr   = 1'b0;
    sh_depth_next = coll_depth;
    sh_dout   = coll_depth;
    if (sh_tag == TAG_INPUT) begin
      sh_kind = KIND_INPUT;
      sh_res  = |sh_value[31:9];
    end else if (sh_tag == TAG_OUTPUT) begin
      sh_kind = KIND_OUTPUT;
      sh_res  = |sh_value[31:9];
    end else if (sh_tag == TAG_FEATURE) begin
      sh_kind = KIND_FEATURE;
      sh_res  = |sh_value[31:9];
    end else if (sh_tag == TAG_COLLECTION) begin
      sh_kind = KIND_COLLECTION;
      sh_res  = sh_value > MAX_COLL_TYPE;
      if (coll_depth >= DEPTH_MAX) begin
        sh_derr       = 1'b1;
        sh_depth_next = DEPTH_MAX;
      end else begin
        sh_depth_next = coll_depth + DEPTH_BITS'(1);
      end
    end else if (sh_tag == TAG_END_COLL) begin
      sh_kind = KIND_END_COLL;
      if (coll_depth == '0) begin
        sh_derr = 1'b1;
      end else begin
        sh_depth_next = coll_depth - DEPTH_BITS'(1);
      end
      sh_dout = sh_depth_next;
    end else if (is_known_tag(sh_tag)) begin
      sh_kind = KIND_KNOWN;
    end
  end

  always_comb begin
    phase_next       = phase;
    held_prefix_next = held_prefix;
    bytes_left_next  = bytes_left;
    byte_slot_next   = byte_slot;
    value_acc_next   = value_acc;
    position_next    = position + OFFSET_BITS'(1);
    item_start_next  = item_start;
    coll_depth_next  = coll_depth;
    produce          = 1'b0;

    res_new           = '0;
    res_new.kind      = KIND_LONG;
    res_new.prefix    = held_prefix & TAG_MASK;
    res_new.offset    = start_wide[15:0];
    res_new.depth     = cd_wide[3:0];
    res_new.done      = last_byte;

    case (phase)
      PH_PREFIX: begin
        item_start_next  = position;
        held_prefix_next = desc_byte;
        value_acc_next   = '0;
        byte_slot_next   = '0;
        res_new.offset   = pos_wide[15:0];
        if (desc_byte == 8'd0 && last_byte && trailing_null_ends) begin
          produce        = 1'b1;
          res_new.kind   = KIND_NULL;
          res_new.prefix = 8'd0;
        end else if (desc_byte == LONG_PREFIX) begin
          phase_next     = PH_LSIZE;
          produce        = last_byte;
          res_new.prefix = desc_byte & TAG_MASK;
        end else begin
          bytes_left_next = 9'(size_of(desc_byte));
          if (size_of(desc_byte) == 3'd0 || last_byte) begin
            produce = 1'b1;
          end else begin
            phase_next = PH_SHORT;
          end
        end
      end
      PH_SHORT: begin
        value_acc_next  = acc_merged;
        byte_slot_next  = byte_slot + 2'd1;
        bytes_left_next = bl_dec;
        produce         = (bl_dec == 9'd0) || last_byte;
      end
      PH_LSIZE: begin
        value_acc_next  = 32'(desc_byte);
        bytes_left_next = 9'(desc_byte) + 9'd1;
        phase_next      = PH_LBODY;
        produce         = last_byte;
        res_new.value   = 32'(desc_byte);
      end
      PH_LBODY: begin
        bytes_left_next = bl_dec;
        res_new.value   = value_acc;
        if (bl_dec == 9'd0 || last_byte) begin
          phase_next = PH_PREFIX;
          produce    = 1'b1;
        end
      end
      default: begin
        phase_next = PH_PREFIX;
      end
    endcase

    if ((phase == PH_PREFIX || phase == PH_SHORT) && produce && res_new.kind != KIND_NULL
        && !(phase == PH_PREFIX && desc_byte == LONG_PREFIX)) begin
      res_new.kind      = sh_kind;
      res_new.prefix    = sh_prefix & TAG_MASK;
      res_new.size      = size_of(sh_prefix);
      res_new.value     = sh_value;
      res_new.depth     = sh_dout_wide[3:0];
      res_new.reserved  = sh_res;
      res_new.depth_err = sh_derr;
      coll_depth_next   = sh_depth_next;
      phase_next        = PH_PREFIX;
    end

    if (last_byte) begin
      phase_next      = PH_PREFIX;
      position_next   = '0;
      coll_depth_next = '0;
      bytes_left_next = '0;
      byte_slot_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trailing_null_ends <= 1'b1;
    end else if (cfg_write) begin
      trailing_null_ends <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_PREFIX;
      held_prefix <= '0;
      bytes_left  <= '0;
      byte_slot   <= '0;
      value_acc   <= '0;
      position    <= '0;
      item_start  <= '0;
      coll_depth  <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      held_prefix <= held_prefix_next;
      bytes_left  <= bytes_left_next;
      byte_slot   <= byte_slot_next;
      value_acc   <= value_acc_next;
      position    <= position_next;
      item_start  <= item_start_next;
      coll_depth  <= coll_depth_next;
    end
  end

  // The skid entry only fills when the output register is held by out_stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && out_stall) begin
      if (accept && produce) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= accept && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_stall) begin
      if (accept && produce) begin
        skid_reg <= res_new;
      end
    end else if (skid_valid) begin
      out_reg <= skid_reg;
    end else if (accept && produce) begin
      out_reg <= res_new;
    end
  end

  assign item_kind       = out_reg.kind;
  assign item_prefix     = out_reg.prefix;
  assign data_size       = out_reg.size;
  assign item_value      = out_reg.value;
  assign item_offset     = out_reg.offset;
  assign nesting_depth   = out_reg.depth;
  assign reserved_flag   = out_reg.reserved;
  assign depth_error     = out_reg.depth_err;
  assign descriptor_done = out_reg.done;

endmodule

[design/hidp_checker.sv]
module hidp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  item_kind,
  input logic [7:0]  item_prefix,
  input logic [2:0]  data_size,
  input logic [31:0] item_value,
  input logic        reserved_flag,
  input logic        depth_error,
  input logic        descriptor_done
);
  import hidp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_null_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == KIND_NULL |->
      item_prefix == 8'd0 && data_size == 3'd0 && item_value == 32'd0 &&
      !reserved_flag && !depth_error && descriptor_done)
    else $error("terminator result carries item data");

  a_long_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == KIND_LONG |->
      item_prefix == TAG_MASK && data_size == 3'd0 && !reserved_flag && !depth_error)
    else $error("long item result malformed");

  a_flag_scope: assert property (@(posedge clk) disable iff (rst)
    out_valid && reserved_flag |->
      item_kind == KIND_INPUT || item_kind == KIND_OUTPUT ||
      item_kind == KIND_FEATURE || item_kind == KIND_COLLECTION)
    else $error("reserved flag on an item kind that cannot carry it");

endmodule

bind hid_descriptor_item_parser_unit hidp_checker u_hidp_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .item_kind       (item_kind),
  .item_prefix     (item_prefix),
  .data_size       (data_size),
  .item_value      (item_value),
  .reserved_flag   (reserved_flag),
  .depth_error     (depth_error),
  .descriptor_done (descriptor_done)
);

[tb/tb_hid_descriptor_item_parser_unit.sv]
`timescale 1ns / 1ps

module tb_hid_descriptor_item_parser_unit;
  import hidp_pkg::*;

  localparam int DEPTH_CAP = MAX_DEPTH_DEF;
  localparam logic [7:0] KNOWN_TAGS [22] = '{
    8'h04, 8'h08, 8'h14, 8'h18, 8'h24, 8'h28, 8'h34, 8'h38, 8'h44, 8'h48, 8'h54,
    8'h58, 8'h64, 8'h74, 8'h78, 8'h84, 8'h88, 8'h94, 8'h98, 8'ha4, 8'ha8, 8'hb4
  };

  typedef struct {
    logic [7:0] data;
    logic       fin;
    bit         typed;
    result_t    want;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic        cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  desc_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  item_kind;
  logic [7:0]  item_prefix;
  logic [2:0]  data_size;
  logic [31:0] item_value;
  logic [15:0] item_offset;
  logic [3:0]  nesting_depth;
  logic        reserved_flag;
  logic        depth_error;
  logic        descriptor_done;

  hid_descriptor_item_parser_unit DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .desc_byte       (desc_byte),
    .last_byte       (last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .item_kind       (item_kind),
    .item_prefix     (item_prefix),
    .data_size       (data_size),
    .item_value      (item_value),
    .item_offset     (item_offset),
    .nesting_depth   (nesting_depth),
    .reserved_flag   (reserved_flag),
    .depth_error     (depth_error),
    .descriptor_done (descriptor_done)
  );

  always #5 clk = ~clk;

  // Parser state as seen from the descriptor stream.
  logic        null_ends;
  phase_t      parse_ph;
  logic [7:0]  held;
  logic [8:0]  remaining;
  logic [1:0]  slot;
  logic [31:0] acc;
  logic [15:0] pos;
  logic [15:0] start;
  logic [3:0]  nest;

  result_t     pending_items[$];
  logic [7:0]  desc_q[$];
  bit          idle_on;
  int          stall_left;
  int          fails = 0;

  function automatic result_t pack_item(input logic [3:0] kind, input logic [7:0] prefix,
                                        input logic [2:0] size, input logic [31:0] value,
                                        input logic [15:0] offset, input logic [3:0] depth,
                                        input logic res, input logic derr,
                                        input logic done);
    result_t r;
    r.kind      = kind;
    r.prefix    = prefix & TAG_MASK;
    r.size      = size;
    r.value     = value;
    r.offset    = offset;
    r.depth     = depth;
    r.reserved  = res;
    r.depth_err = derr;
    r.done      = done;
    return r;
  endfunction

  function automatic logic [2:0] announced_size(input logic [7:0] p);
    return (p[1:0] == 2'd3) ? 3'd4 : {1'b0, p[1:0]};
  endfunction

  function automatic result_t close_short(input logic done);
    logic [7:0] tag;
    logic [3:0] kind;
    logic [3:0] dout;
    logic       res;
    logic       derr;
    tag  = held & TAG_MASK;
    kind = KIND_RESERVED;
    res  = 1'b0;
    derr = 1'b0;
    dout = nest;
    case (tag)
      TAG_INPUT: begin
        kind = KIND_INPUT;
        res  = |acc[31:9];
      end
      TAG_OUTPUT: begin
        kind = KIND_OUTPUT;
        res  = |acc[31:9];
      end
      TAG_FEATURE: begin
        kind = KIND_FEATURE;
        res  = |acc[31:9];
      end
      TAG_COLLECTION: begin
        kind = KIND_COLLECTION;
        res  = acc > MAX_COLL_TYPE;
        if (nest >= DEPTH_CAP) begin
          derr = 1'b1;
          nest = 4'(DEPTH_CAP);
        end else begin
          nest = nest + 4'd1;
        end
      end
      TAG_END_COLL: begin
        kind = KIND_END_COLL;
        if (nest == 4'd0) derr = 1'b1;
        else nest = nest - 4'd1;
        dout = nest;
      end
      default: begin
        foreach (KNOWN_TAGS[i]) if (KNOWN_TAGS[i] == tag) kind = KIND_KNOWN;
      end
    endcase
    parse_ph = PH_PREFIX;
    return pack_item(kind, held, announced_size(held), acc, start, dout, res, derr, done);
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic fin, output result_t r);
    bit          got;
    logic [15:0] p;
    got = 1'b0;
    p   = pos;
    r   = '0;
    pos = p + 16'd1;
    case (parse_ph)
      PH_PREFIX: begin
        start = p;
        held  = b;
        acc   = '0;
        slot  = '0;
        if (b == 8'h00 && fin && null_ends) begin
          r   = pack_item(KIND_NULL, 8'h00, 3'd0, '0, start, nest, 1'b0, 1'b0, 1'b1);
          got = 1'b1;
        end else if (b == LONG_PREFIX) begin
          parse_ph = PH_LSIZE;
          if (fin) begin
            r   = pack_item(KIND_LONG, b, 3'd0, '0, start, nest, 1'b0, 1'b0, 1'b1);
            got = 1'b1;
          end
        end else begin
          remaining = {6'd0, announced_size(b)};
          if (remaining == 9'd0 || fin) begin
            r   = close_short(fin);
            got = 1'b1;
          end else begin
            parse_ph = PH_SHORT;
          end
        end
      end
      PH_SHORT: begin
        acc       = acc | (32'(b) << (8 * slot));
        slot      = slot + 2'd1;
        remaining = remaining - 9'd1;
        if (remaining == 9'd0 || fin) begin
          r   = close_short(fin);
          got = 1'b1;
        end
      end
      PH_LSIZE: begin
        acc       = 32'(b);
        remaining = {1'b0, b} + 9'd1;
        parse_ph  = PH_LBODY;
        if (fin) begin
          r   = pack_item(KIND_LONG, held, 3'd0, 32'(b), start, nest, 1'b0, 1'b0, 1'b1);
          got = 1'b1;
        end
      end
      default: begin
        remaining = remaining - 9'd1;
        if (remaining == 9'd0 || fin) begin
          parse_ph = PH_PREFIX;
          r   = pack_item(KIND_LONG, held, 3'd0, acc, start, nest, 1'b0, 1'b0, fin);
          got = 1'b1;
        end
      end
    endcase
    if (fin) begin
      parse_ph  = PH_PREFIX;
      pos       = '0;
      nest      = '0;
      remaining = '0;
      slot      = '0;
    end
    return got;
  endfunction

  // Called right after a falling edge; returns right after the falling edge that follows the accepted byte.
  task automatic send_byte(input logic [7:0] b, input logic fin, input bit typed,
                           input result_t want);
    result_t r;
    bit      got;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    desc_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = parse_byte(b, fin, r);
    if (typed) pending_items.push_back(want);
    else if (got) pending_items.push_back(r);
    @(negedge clk);
  endtask

  task automatic send_descriptor();
    foreach (desc_q[i]) send_byte(desc_q[i], i == desc_q.size() - 1, 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_items.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_null_ends(input logic v);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
    null_ends = v;
  endtask

  task automatic push_short(input logic [7:0] prefix, input logic [31:0] value);
    logic [2:0] n;
    n = announced_size(prefix);
    desc_q.push_back(prefix);
    for (int i = 0; i < n; i++) desc_q.push_back(value[8 * i +: 8]);
  endtask

  task automatic push_long(input logic [7:0] len);
    desc_q.push_back(LONG_PREFIX);
    desc_q.push_back(len);
    desc_q.push_back(8'($urandom));
    for (int i = 0; i < len; i++) desc_q.push_back(8'($urandom));
  endtask

  task automatic build_descriptor(input bit deep);
    int          n_items;
    int          sel;
    int          cut;
    logic [7:0]  code;
    logic [7:0]  tag;
    logic [31:0] value;
    desc_q.delete();
    n_items = $urandom_range(1, 30);
    for (int k = 0; k < n_items; k++) begin
      sel   = $urandom_range(0, 99);
      code  = 8'($urandom_range(0, 3));
      value = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 511);
      if (deep) sel = (sel < 60) ? 20 : (sel < 70) ? 35 : sel;
      if (sel < 15) begin
        case ($urandom_range(0, 2))
          0: tag = TAG_INPUT;
          1: tag = TAG_OUTPUT;
          default: tag = TAG_FEATURE;
        endcase
        push_short(tag | code, value);
      end else if (sel < 30) begin
        value = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7);
        push_short(TAG_COLLECTION | code, value);
      end else if (sel < 45) begin
        push_short(TAG_END_COLL | code, value);
      end else if (sel < 70) begin
        push_short(KNOWN_TAGS[5'($urandom_range(0, 21))] | code, value);
      end else if (sel < 80) begin
        push_short(8'($urandom), value);
      end else if (sel < 90) begin
        push_long(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)));
      end else begin
        push_short(8'h00, '0);
      end
    end
    if ($urandom_range(0, 2) == 0) desc_q.push_back(8'h00);
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, desc_q.size());
      while (desc_q.size() > cut) void'(desc_q.pop_back());
    end
  endtask

  task automatic run_random(input int target, input bit deep);
    int made;
    made = 0;
    while (made < target) begin
      build_descriptor(deep || $urandom_range(0, 7) == 0);
      send_descriptor();
      made += desc_q.size();
    end
  endtask

  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 9);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_output
    result_t seen;
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      seen = {item_kind, item_prefix, data_size, item_value, item_offset, nesting_depth,
              reserved_flag, depth_error, descriptor_done};
      if (pending_items.size() == 0) begin
        $error("unexpected item: item_kind %0d item_offset %0d", seen.kind, seen.offset);
        fails++;
      end else begin
        want = pending_items.pop_front();
        if (seen !== want) fails++;
        if (seen.kind !== want.kind)
          $error("item_kind expected %0d actual %0d", want.kind, seen.kind);
        if (seen.prefix !== want.prefix)
          $error("item_prefix expected %h actual %h", want.prefix, seen.prefix);
        if (seen.size !== want.size)
          $error("data_size expected %0d actual %0d", want.size, seen.size);
        if (seen.value !== want.value)
          $error("item_value expected %h actual %h", want.value, seen.value);
        if (seen.offset !== want.offset)
          $error("item_offset expected %0d actual %0d", want.offset, seen.offset);
        if (seen.depth !== want.depth)
          $error("nesting_depth expected %0d actual %0d", want.depth, seen.depth);
        if (seen.reserved !== want.reserved)
          $error("reserved_flag expected %b actual %b", want.reserved, seen.reserved);
        if (seen.depth_err !== want.depth_err)
          $error("depth_error expected %b actual %b", want.depth_err, seen.depth_err);
        if (seen.done !== want.done)
          $error("descriptor_done expected %b actual %b", want.done, seen.done);
      end
    end
  end

  initial begin
    #20000000;
    $display("tb_hid_descriptor_item_parser_unit failed");
    $finish;
  end

  initial begin
    directed_row_t rows[$];
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_data  = 1'b0;
    in_valid  = 1'b0;
    desc_byte = 8'h00;
    last_byte = 1'b0;
    idle_on   = 1'b1;
    null_ends = 1'b1;
    parse_ph  = PH_PREFIX;
    held      = '0;
    remaining = '0;
    slot      = '0;
    acc       = '0;
    pos       = '0;
    start     = '0;
    nest      = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // A zero prefix that is not the final byte is an ordinary reserved item.
    rows.push_back('{8'h00, 1'b0, 1'b1,
                     pack_item(KIND_RESERVED, 8'h00, 3'd0, '0, 16'd0, 4'd0, 1'b0, 1'b0, 1'b0)});
    rows.push_back('{8'ha1, 1'b0, 1'b0, '0});
    rows.push_back('{8'h07, 1'b0, 1'b1,
                     pack_item(KIND_COLLECTION, TAG_COLLECTION, 3'd1, 32'd7, 16'd1, 4'd0,
                               1'b1, 1'b0, 1'b0)});
    rows.push_back('{8'h83, 1'b0, 1'b0, '0});
    repeat (3) rows.push_back('{8'hff, 1'b0, 1'b0, '0});
    rows.push_back('{8'hff, 1'b0, 1'b1,
                     pack_item(KIND_INPUT, TAG_INPUT, 3'd4, 32'hffffffff, 16'd3, 4'd1,
                               1'b1, 1'b0, 1'b0)});
    rows.push_back('{8'h92, 1'b0, 1'b0, '0});
    rows.push_back('{8'h00, 1'b0, 1'b0, '0});
    rows.push_back('{8'h02, 1'b0, 1'b0, '0});
    rows.push_back('{8'hb2, 1'b0, 1'b0, '0});
    rows.push_back('{8'hff, 1'b0, 1'b0, '0});
    rows.push_back('{8'h01, 1'b0, 1'b0, '0});
    rows.push_back('{8'hc0, 1'b0, 1'b0, '0});
    // End collection with no collection open.
    rows.push_back('{8'hc0, 1'b0, 1'b1,
                     pack_item(KIND_END_COLL, TAG_END_COLL, 3'd0, '0, 16'd15, 4'd0,
                               1'b0, 1'b1, 1'b0)});
    rows.push_back('{8'h05, 1'b0, 1'b0, '0});
    rows.push_back('{8'h01, 1'b0, 1'b0, '0});
    rows.push_back('{LONG_PREFIX, 1'b0, 1'b0, '0});
    rows.push_back('{8'h02, 1'b0, 1'b0, '0});
    rows.push_back('{8'h10, 1'b0, 1'b0, '0});
    rows.push_back('{8'haa, 1'b0, 1'b0, '0});
    rows.push_back('{8'hbb, 1'b0, 1'b0, '0});
    rows.push_back('{8'h00, 1'b1, 1'b1,
                     pack_item(KIND_NULL, 8'h00, 3'd0, '0, 16'd23, 4'd0, 1'b0, 1'b0, 1'b1)});
    // A long prefix as the final byte, then a short item cut off by the final byte.
    rows.push_back('{LONG_PREFIX, 1'b1, 1'b1,
                     pack_item(KIND_LONG, LONG_PREFIX, 3'd0, '0, 16'd0, 4'd0, 1'b0, 1'b0, 1'b1)});
    rows.push_back('{8'h83, 1'b0, 1'b0, '0});
    rows.push_back('{8'h12, 1'b1, 1'b0, '0});
    foreach (rows[i]) send_byte(rows[i].data, rows[i].fin, rows[i].typed, rows[i].want);

    write_null_ends(1'b0);
    run_random(280, 1'b0);

    write_null_ends(1'b1);
    run_random(220, 1'b0);

    write_null_ends(1'b0);
    run_random(130, 1'b1);

    write_null_ends(1'b1);
    idle_on = 1'b0;
    run_random(180, 1'b0);
    in_valid <= 1'b0;

    while (pending_items.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0 && pending_items.size() == 0) begin
      $display("tb_hid_descriptor_item_parser_unit passed");
    end else begin
      $display("tb_hid_descriptor_item_parser_unit failed");
    end
    $finish;
  end

endmodule

[files.f]
design/hidp_pkg.sv
design/hid_descriptor_item_parser_unit.sv
design/hidp_checker.sv
tb/tb_hid_descriptor_item_parser_unit.sv
